>>> rtl/utf8d_pkg.sv
// shared types and constants for the lenient utf-8 decoder
`timescale 1ns / 1ps
`default_nettype none
package utf8d_pkg;

	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] REPL_CP = CP_W'(63);

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            replaced;
		logic            run_last;
	} out_word_t;

	// work for the back end: qmarks replacement words, then an optional decoded code point
	typedef struct packed {
		logic [2:0]      qmarks;
		logic            tail_v;
		logic [CP_W-1:0] tail_cp;
	} job_t;

endpackage
`default_nettype wire

>>> rtl/utf8d_front.sv
// front end: takes bytes, tracks the open sequence and classifies each byte into a job
`timescale 1ns / 1ps
`default_nettype none
module utf8d_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire utf8d_pkg::in_word_t item,
	output logic                    full,
	input  wire logic               q_full,
	output logic                    job_push,
	output utf8d_pkg::job_t         job
);

	logic [utf8d_pkg::CP_W-1:0] pv_q, pv_d;
	logic [1:0]                 bse_q, bse_d;
	logic [1:0]                 held_q, held_d;

	logic [7:0]                 b;
	logic                       eot, accept, open, cont, lead;
	logic [utf8d_pkg::CP_W-1:0] pv_shift, lead_bits;
	logic [1:0]                 lead_need;
	logic [2:0]                 base_q;

	assign b      = item.byte_in;
	assign eot    = item.end_of_text;
	assign full   = q_full;
	assign accept = push && !q_full;
	assign open   = (bse_q != 2'd0);
	assign cont   = (b[7:6] == 2'b10);
	assign pv_shift = {pv_q[utf8d_pkg::CP_W-7:0], b[5:0]};
	assign base_q = open ? (3'd1 + {1'b0, held_q}) : 3'd0;

	always_comb begin
		lead      = 1'b1;
		lead_bits = '0;
		lead_need = 2'd0;
		if (b[7:5] == 3'b110) begin
			lead_bits = {16'd0, b[4:0]};
			lead_need = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			lead_bits = {17'd0, b[3:0]};
			lead_need = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			lead_bits = {18'd0, b[2:0]};
			lead_need = 2'd3;
		end else begin
			lead = 1'b0;
		end
	end

	always_comb begin
		job.qmarks  = 3'd0;
		job.tail_v  = 1'b0;
		job.tail_cp = {13'd0, b};
		pv_d        = '0;
		bse_d       = 2'd0;
		held_d      = 2'd0;
		if (open && cont) begin
			if (bse_q == 2'd1) begin
				job.tail_v  = 1'b1;
				job.tail_cp = pv_shift;
			end else if (eot) begin
				job.qmarks = 3'd2 + {1'b0, held_q};
			end else begin
				pv_d   = pv_shift;
				bse_d  = bse_q - 2'd1;
				held_d = held_q + 2'd1;
			end
		end else begin
			job.qmarks = base_q;
			if (!b[7]) begin
				job.tail_v = 1'b1;
			end else if (lead && !eot) begin
				pv_d  = lead_bits;
				bse_d = lead_need;
			end else begin
				job.qmarks = base_q + 3'd1;
			end
		end
	end

	assign job_push = accept && (job.tail_v || (job.qmarks != 3'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			bse_q  <= 2'd0;
			held_q <= 2'd0;
		end else if (accept) begin
			pv_q   <= pv_d;
			bse_q  <= bse_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/utf8d_fifo.sv
// small job queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none
module utf8d_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire utf8d_pkg::job_t wdata,
	output logic                 full,
	input  wire logic            pop,
	output utf8d_pkg::job_t      rdata,
	output logic                 empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	utf8d_pkg::job_t mem [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/utf8d_back.sv
// back end: expands each job into result words, one per cycle while pop is high
`timescale 1ns / 1ps
`default_nettype none
module utf8d_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire utf8d_pkg::job_t    q_job,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output utf8d_pkg::out_word_t    result
);

	logic [2:0]                 qm_q;
	logic                       tail_v_q;
	logic [utf8d_pkg::CP_W-1:0] tail_cp_q;
	logic                       busy, take, last, done;

	assign busy  = (qm_q != 3'd0) || tail_v_q;
	assign empty = !busy;
	assign take  = pop && busy;

	always_comb begin
		if (qm_q != 3'd0) begin
			result.code_point = utf8d_pkg::REPL_CP;
			result.replaced   = 1'b1;
			last              = (qm_q == 3'd1) && !tail_v_q;
		end else begin
			result.code_point = tail_cp_q;
			result.replaced   = 1'b0;
			last              = 1'b1;
		end
		result.run_last = last;
	end

	assign done  = !busy || (take && last);
	assign q_pop = done && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tail_cp_q <= q_job.tail_cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q     <= 3'd0;
			tail_v_q <= 1'b0;
		end else if (q_pop) begin
			qm_q     <= q_job.qmarks;
			tail_v_q <= q_job.tail_v;
		end else if (take) begin
			if (qm_q != 3'd0) begin
				qm_q <= qm_q - 3'd1;
			end else begin
				tail_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/utf8_lenient_decoder.sv
// top level of the lenient utf-8 decoder
// Bytes go in on the push/full side, one word per cycle while full is low, and decoded code
// points come out on the empty/pop side. A byte may yield several result words (up to four
// on a broken or truncated sequence). A QDEPTH-entry job queue between the byte classifier
// and the result expander absorbs those bursts, and full rises only when that queue is full.
// An accepted byte's words are queued as a job, which is then loaded into the result
// expander's registers, from which its first result word is shown. Malformed input gives
// '?' (63) with replaced set; run_last marks the last word caused by a byte.
`timescale 1ns / 1ps
`default_nettype none
module utf8_lenient_decoder #(
	parameter int unsigned QDEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire utf8d_pkg::in_word_t item,
	output logic                     full,
	output logic                     empty,
	input  wire logic                pop,
	output utf8d_pkg::out_word_t     result
);

	logic            q_full, q_empty, q_push, q_pop;
	utf8d_pkg::job_t job_w, job_r;

	utf8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (q_full),
		.job_push (q_push),
		.job      (job_w)
	);

	utf8d_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (job_w),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (job_r),
		.empty  (q_empty)
	);

	utf8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (job_r),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire

>>> rtl/utf8d_checker.sv
// port-level checks for the lenient utf-8 decoder and their binding
`timescale 1ns / 1ps
`default_nettype none
module utf8d_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 empty,
	input wire logic                 pop,
	input wire utf8d_pkg::out_word_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result word changed while stalled");

	a_repl_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.replaced) |-> (result.code_point == utf8d_pkg::REPL_CP))
		else $error("replacement word without '?'");

	a_run_repl: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.run_last) |-> result.replaced)
		else $error("decoded code point not last of its run");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.run_last) |=> !empty)
		else $error("run ended before its last word");

endmodule

bind utf8_lenient_decoder utf8d_checker u_chk (.*);
`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the lenient utf-8 decoder: byte stream in, checked code point words out
`timescale 1ns / 1ps
module tb;

	localparam int LIMIT = 200000;
	localparam int LONG_HOLD = 150;
	localparam int CPW = utf8d_pkg::CP_W;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 pop = 1'b0;
	utf8d_pkg::in_word_t  item = '0;
	logic                 full;
	logic                 empty;
	utf8d_pkg::out_word_t result;

	utf8_lenient_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	utf8d_pkg::in_word_t  pending[$];
	utf8d_pkg::out_word_t cp_expect[$];
	utf8d_pkg::out_word_t burst[$];

	logic [CPW-1:0] seq_cp = '0;
	logic [1:0]     seq_need = '0;
	logic [1:0]     seq_held = '0;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_reqs = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	bit  in_taken = 1'b0;
	int  queued_cnt = 0;
	int  accepted_cnt = 0;
	int  words_seen = 0;
	int  repl_seen = 0;
	int  errors = 0;
	int  cycle_cnt = 0;
	int  full_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void emit_word(input logic [CPW-1:0] cp, input logic repl);
		utf8d_pkg::out_word_t w;
		w.code_point = cp;
		w.replaced = repl;
		w.run_last = 1'b0;
		burst = {burst, w};
	endfunction

	function automatic void decode_byte(input utf8d_pkg::in_word_t w);
		logic [7:0]     b;
		logic [CPW-1:0] bits;
		logic [1:0]     n;
		b = w.byte_in;
		bits = '0;
		n = '0;
		burst = {};
		if (seq_need != 0 && b[7:6] == 2'b10) begin
			seq_cp = (seq_cp << 6) | CPW'(b[5:0]);
			seq_need = seq_need - 2'd1;
			if (seq_need == 0) begin
				emit_word(seq_cp, 1'b0);
				seq_cp = '0;
				seq_held = '0;
			end else if (w.end_of_text) begin
				repeat (int'(seq_held) + 2) emit_word(utf8d_pkg::REPL_CP, 1'b1);
			end else begin
				seq_held = seq_held + 2'd1;
			end
		end else begin
			// broken sequence: one '?' for the lead and each held continuation
			if (seq_need != 0)
				repeat (int'(seq_held) + 1) emit_word(utf8d_pkg::REPL_CP, 1'b1);
			seq_cp = '0;
			seq_need = '0;
			seq_held = '0;
			if (!b[7]) begin
				emit_word(CPW'(b), 1'b0);
			end else begin
				if (b[7:5] == 3'b110) begin
					bits = CPW'(b[4:0]);
					n = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					bits = CPW'(b[3:0]);
					n = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					bits = CPW'(b[2:0]);
					n = 2'd3;
				end
				if (n == 0 || w.end_of_text) begin
					emit_word(utf8d_pkg::REPL_CP, 1'b1);
				end else begin
					seq_cp = bits;
					seq_need = n;
				end
			end
		end
		if (w.end_of_text) begin
			seq_cp = '0;
			seq_need = '0;
			seq_held = '0;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].run_last = 1'b1;
		foreach (burst[i])
			cp_expect = {cp_expect, burst[i]};
	endfunction

	function automatic void note_mismatch(input string what, input utf8d_pkg::out_word_t want,
			input utf8d_pkg::out_word_t got);
		errors++;
		if (errors <= 10)
			$display("mismatch (%s): expected cp=%h repl=%b last=%b, got cp=%h repl=%b last=%b",
				what, want.code_point, want.replaced, want.run_last,
				got.code_point, got.replaced, got.run_last);
	endfunction

	always @(negedge clk) begin : drive_bytes
		logic busy;
		busy = push && !in_taken;
		in_taken = 1'b0;
		if (!busy) begin
			if (arst_n && pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= pending.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_pop
		if (hold_served != hold_reqs) begin
			hold_left = LONG_HOLD;
			hold_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : watch
		utf8d_pkg::out_word_t want;
		cycle_cnt++;
		if (arst_n && full)
			full_cycles++;
		if (arst_n && push && !full) begin
			in_taken = 1'b1;
			accepted_cnt++;
			decode_byte(item);
		end
		if (arst_n && pop && !empty) begin
			if (cp_expect.size() == 0) begin
				note_mismatch("unexpected word", '0, result);
			end else begin
				want = cp_expect.pop_front();
				words_seen++;
				if (want.replaced)
					repl_seen++;
				if (result.code_point !== want.code_point)
					note_mismatch("code_point", want, result);
				else if (result.replaced !== want.replaced)
					note_mismatch("replaced", want, result);
				else if (result.run_last !== want.run_last)
					note_mismatch("run_last", want, result);
			end
		end
		if (cycle_cnt > LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
				cp_expect.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		utf8d_pkg::in_word_t w;
		w.byte_in = b;
		w.end_of_text = eot;
		pending = {pending, w};
		queued_cnt++;
	endtask

	task automatic send_text(input int count);
		int added;
		int kind;
		int len;
		int conts;
		logic [7:0] lead;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(99);
			len = $urandom_range(4, 1);
			case (len)
				1: lead = 8'($urandom_range(127));
				2: lead = {3'b110, 5'($urandom)};
				3: lead = {4'b1110, 4'($urandom)};
				default: lead = {5'b11110, 3'($urandom)};
			endcase
			if (kind < 75) begin
				// well-formed character
				send_byte(lead, len == 1 && $urandom_range(9) == 0);
				for (int i = 1; i < len; i++)
					send_byte({2'b10, 6'($urandom)}, i == len - 1 && $urandom_range(9) == 0);
				added += len;
			end else if (kind < 87 && len > 1) begin
				// sequence cut short, by end of text or by the next byte
				conts = $urandom_range(len - 2);
				send_byte(lead, conts == 0 && $urandom_range(1) == 0);
				for (int i = 0; i < conts; i++)
					send_byte({2'b10, 6'($urandom)}, i == conts - 1 && $urandom_range(1) == 0);
				added += conts + 1;
			end else begin
				send_byte(8'($urandom), $urandom_range(3) == 0);
				added++;
			end
		end
	endtask

	task automatic wait_drain();
		while (accepted_cnt != queued_cnt || cp_expect.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		send_text(count);
		wait_drain();
	endtask

	initial begin
		// ascii extremes and a literal question mark
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h3F, 1'b0);
		// two, three and four byte characters, the last one the largest value
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// stray continuation and invalid leads
		send_byte(8'h80, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b0);
		// broken sequence
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'h41, 1'b0);
		// cut short at end of text, three words from one byte
		send_byte(8'hF0, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b1);
		// lead flagged end of text, then a break by such a lead
		send_byte(8'hC3, 1'b1);
		send_byte(8'hE1, 1'b0);
		send_byte(8'hC2, 1'b1);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drain();

		// long output hold-off while bytes keep coming
		hold_reqs++;
		run_phase(0, 0, 64);
		run_phase(45, 0, 64);
		run_phase(0, 45, 64);
		run_phase(30, 30, 64);

		wait_drain();
		repeat (20) @(posedge clk);
		$display("sent %0d bytes, checked %0d words (%0d replacements), input stalled %0d cycles",
			accepted_cnt, words_seen, repl_seen, full_cycles);
		$display("%0d mismatches over %0d cycles", errors, cycle_cnt);
		if (errors == 0 && cp_expect.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_fifo.sv
rtl/utf8d_back.sv
rtl/utf8_lenient_decoder.sv
rtl/utf8d_checker.sv
tb/sv/tb.sv
